// ===== src/dpad_to_mouse_event_generator_macros.svh =====
// ----------------------------------------------------------------------------
// D-pad to mouse event generator: assertion macros
// Shared concurrent assertion forms that are clocked and gated by reset.
// ----------------------------------------------------------------------------
`ifndef DPAD_TO_MOUSE_EVENT_GENERATOR_MACROS_SVH
`define DPAD_TO_MOUSE_EVENT_GENERATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DPAD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DPAD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/dpad_pkg.sv =====
// ----------------------------------------------------------------------------
// D-pad to mouse event generator: package
// Event and button codes, pad bit positions, queue sizing and record types.
// ----------------------------------------------------------------------------
package dpad_pkg;

  localparam int PAD_W = 19;

  // Pad bit positions.
  localparam int PAD_UP         = 0;
  localparam int PAD_UP_LEFT    = 1;
  localparam int PAD_LEFT       = 2;
  localparam int PAD_DOWN_LEFT  = 3;
  localparam int PAD_DOWN       = 4;
  localparam int PAD_DOWN_RIGHT = 5;
  localparam int PAD_RIGHT      = 6;
  localparam int PAD_UP_RIGHT   = 7;
  localparam int PAD_MIDDLE     = 12;
  localparam int PAD_RBTN       = 13;
  localparam int PAD_LBTN_A     = 14;
  localparam int PAD_LBTN_B     = 18;

  localparam logic [3:0] STEP_RESET = 4'd2;

  // Event kinds.
  localparam logic [1:0] EV_MOTION = 2'd0;
  localparam logic [1:0] EV_DOWN   = 2'd1;
  localparam logic [1:0] EV_UP     = 2'd2;

  // Button codes; these also index the event mask below.
  localparam logic [1:0] BTN_NONE   = 2'd0;
  localparam logic [1:0] BTN_LEFT   = 2'd1;
  localparam logic [1:0] BTN_MIDDLE = 2'd2;
  localparam logic [1:0] BTN_RIGHT  = 2'd3;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // One tick's outcome. ev_mask bit 0 is motion, bits 1..3 are button
  // changes for left, middle and right.
  typedef struct packed {
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [2:0]  held;
    logic [3:0]  ev_mask;
  } tick_rec_t;

  typedef struct packed {
    logic      push;
    tick_rec_t rec;
  } front_wr_t;

  typedef struct packed {
    logic      avail;
    tick_rec_t rec;
  } queue_rd_t;

endpackage

// ===== src/dpad_front.sv =====
// ----------------------------------------------------------------------------
// D-pad front end
// Decodes a pad sample, moves the pointer with saturation, tracks the held
// button mask and queues a record for every tick that causes events.
// ----------------------------------------------------------------------------
module dpad_front import dpad_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [PAD_W-1:0] pad,
  input  logic             cfg_we,
  input  logic [3:0]       cfg_step,
  output front_wr_t        wr
);

  logic [3:0]  step_r;
  logic [15:0] pos_x_r, pos_y_r;
  logic [2:0]  prev_held_r;

  logic        x_neg, x_pos, y_neg, y_pos;
  logic [2:0]  held;
  logic signed [17:0] delta_x, delta_y, sum_x, sum_y;
  logic [15:0] nx, ny;
  logic        moved;

  // Later checks win, so the diagonals override the single directions.
  always_comb begin
    x_neg = 1'b0;
    x_pos = 1'b0;
    y_neg = 1'b0;
    y_pos = 1'b0;
    if (pad[PAD_UP]) begin
      y_neg = 1'b1; y_pos = 1'b0;
    end
    if (pad[PAD_DOWN]) begin
      y_neg = 1'b0; y_pos = 1'b1;
    end
    if (pad[PAD_LEFT]) begin
      x_neg = 1'b1; x_pos = 1'b0;
    end
    if (pad[PAD_RIGHT]) begin
      x_neg = 1'b0; x_pos = 1'b1;
    end
    if (pad[PAD_UP_LEFT]) begin
      y_neg = 1'b1; y_pos = 1'b0; x_neg = 1'b1; x_pos = 1'b0;
    end
    if (pad[PAD_UP_RIGHT]) begin
      y_neg = 1'b1; y_pos = 1'b0; x_neg = 1'b0; x_pos = 1'b1;
    end
    if (pad[PAD_DOWN_LEFT]) begin
      y_neg = 1'b0; y_pos = 1'b1; x_neg = 1'b1; x_pos = 1'b0;
    end
    if (pad[PAD_DOWN_RIGHT]) begin
      y_neg = 1'b0; y_pos = 1'b1; x_neg = 1'b0; x_pos = 1'b1;
    end
  end

  assign held = {pad[PAD_RBTN], pad[PAD_MIDDLE], pad[PAD_LBTN_B] | pad[PAD_LBTN_A]};

  always_comb begin
    delta_x = 18'sd0;
    delta_y = 18'sd0;
    if (x_pos) delta_x = $signed({14'd0, step_r});
    if (x_neg) delta_x = -$signed({14'd0, step_r});
    if (y_pos) delta_y = $signed({14'd0, step_r});
    if (y_neg) delta_y = -$signed({14'd0, step_r});
    sum_x = $signed({{2{pos_x_r[15]}}, pos_x_r}) + delta_x;
    sum_y = $signed({{2{pos_y_r[15]}}, pos_y_r}) + delta_y;
    if (sum_x > 18'sd32767)       nx = 16'h7FFF;
    else if (sum_x < -18'sd32768) nx = 16'h8000;
    else                          nx = sum_x[15:0];
    if (sum_y > 18'sd32767)       ny = 16'h7FFF;
    else if (sum_y < -18'sd32768) ny = 16'h8000;
    else                          ny = sum_y[15:0];
  end

  assign moved = (nx != pos_x_r) || (ny != pos_y_r);

  always_comb begin
    wr.rec.pos_x   = nx;
    wr.rec.pos_y   = ny;
    wr.rec.held    = held;
    wr.rec.ev_mask = {held ^ prev_held_r, moved};
    wr.push        = accept && (wr.rec.ev_mask != 4'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= STEP_RESET;
      pos_x_r     <= 16'd0;
      pos_y_r     <= 16'd0;
      prev_held_r <= 3'd0;
    end else begin
      if (cfg_we) step_r <= cfg_step;
      if (accept) begin
        pos_x_r     <= nx;
        pos_y_r     <= ny;
        prev_held_r <= held;
      end
    end
  end

endmodule

// ===== src/dpad_fifo.sv =====
// ----------------------------------------------------------------------------
// D-pad tick queue
// A short first-in first-out queue of tick records between front and back.
// ----------------------------------------------------------------------------
module dpad_fifo import dpad_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  front_wr_t wr,
  input  logic      pop,
  output queue_rd_t rd,
  output logic      full
);

  tick_rec_t             mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CNT_W-1:0] cnt_r;
  logic                  do_pop;

  assign full     = (cnt_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign rd.avail = (cnt_r != '0);
  assign rd.rec   = mem_r[rd_ptr_r];
  assign do_pop   = pop && rd.avail;

  always_ff @(posedge clk) begin
    if (wr.push) mem_r[wr_ptr_r] <= wr.rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr.push) begin
        wr_ptr_r <= (wr_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({wr.push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== src/dpad_back.sv =====
// ----------------------------------------------------------------------------
// D-pad back end
// Walks the pending event bits of one tick record and drives one mouse
// event per cycle while out_stall is low, through a registered output stage.
// ----------------------------------------------------------------------------
module dpad_back import dpad_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  queue_rd_t   rd,
  output logic        pop,
  input  logic        out_stall,
  output logic        out_valid,
  output logic [1:0]  out_event_kind,
  output logic [1:0]  out_which_button,
  output logic [15:0] out_pointer_x,
  output logic [15:0] out_pointer_y,
  output logic [2:0]  out_held_mask,
  output logic        out_last_event
);

  tick_rec_t   rec_r;
  logic [3:0]  rem_r, rem_after, rem_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  kind_r, btn_r;
  logic [15:0] px_r, py_r;
  logic [2:0]  held_r;
  logic        last_r;

  logic        load_out, emit;
  logic [1:0]  sel;
  logic [1:0]  kind;

  assign load_out = !out_valid_r || !out_stall;
  assign emit     = load_out && (rem_r != 4'd0);

  // Lowest pending bit goes first: motion, then left, middle, right.
  always_comb begin
    if (rem_r[0])      sel = BTN_NONE;
    else if (rem_r[1]) sel = BTN_LEFT;
    else if (rem_r[2]) sel = BTN_MIDDLE;
    else               sel = BTN_RIGHT;
    if (sel == BTN_NONE)         kind = EV_MOTION;
    else if (rec_r.held[sel - 2'd1]) kind = EV_DOWN;
    else                         kind = EV_UP;
    rem_after = emit ? (rem_r & ~(4'd1 << sel)) : rem_r;
    pop       = rd.avail && (rem_after == 4'd0);
    rem_nxt   = pop ? rd.rec.ev_mask : rem_after;
    if (emit)          out_valid_nxt = 1'b1;
    else if (load_out) out_valid_nxt = 1'b0;
    else               out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r       <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) rec_r <= rd.rec;
    if (emit) begin
      kind_r <= kind;
      btn_r  <= sel;
      px_r   <= rec_r.pos_x;
      py_r   <= rec_r.pos_y;
      held_r <= rec_r.held;
      last_r <= (rem_after == 4'd0);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_kind   = kind_r;
  assign out_which_button = btn_r;
  assign out_pointer_x    = px_r;
  assign out_pointer_y    = py_r;
  assign out_held_mask    = held_r;
  assign out_last_event   = last_r;

endmodule

// ===== src/dpad_to_mouse_event_generator.sv =====
// ----------------------------------------------------------------------------
// D-pad to mouse event generator
// Turns sampled pad button vectors into pointer motion and mouse button
// events.
// ----------------------------------------------------------------------------
// Each accepted pad word moves the pointer by step_size per axis (saturating
// at signed 16 bits) and yields up to four event words: a motion event when
// the position changed, then a down or up event for each changed button in
// the order left, middle, right; last_event marks the final one. Pad words
// are taken while the queue has room, and the result words leave through a
// single output register at one per cycle while out_stall is low; a tick that
// causes no event queues nothing. A four-entry queue between the decoder and
// the event sequencer lets input keep flowing while the output side is
// stalled; in_stall rises only when it is full. step_size is written through
// the cfg port, which is always ready.
// ----------------------------------------------------------------------------
module dpad_to_mouse_event_generator import dpad_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [18:0]        in_pad_buttons,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_event_kind,
  output logic [1:0]         out_which_button,
  output logic signed [15:0] out_pointer_x,
  output logic signed [15:0] out_pointer_y,
  output logic               out_left_pressed,
  output logic [2:0]         out_held_mask,
  output logic               out_last_event,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_step_size
);

  front_wr_t   wr;
  queue_rd_t   rd;
  logic        pop, full, accept;
  logic [15:0] px, py;
  logic [2:0]  held;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;
  assign accept    = in_valid && !full;

  dpad_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .pad      (in_pad_buttons),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_step (cfg_step_size),
    .wr       (wr)
  );

  dpad_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (wr),
    .pop   (pop),
    .rd    (rd),
    .full  (full)
  );

  dpad_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .rd               (rd),
    .pop              (pop),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_event_kind   (out_event_kind),
    .out_which_button (out_which_button),
    .out_pointer_x    (px),
    .out_pointer_y    (py),
    .out_held_mask    (held),
    .out_last_event   (out_last_event)
  );

  assign out_pointer_x    = $signed(px);
  assign out_pointer_y    = $signed(py);
  assign out_held_mask    = held;
  assign out_left_pressed = held[0];

endmodule

// ===== src/dpad_checker.sv =====
// ----------------------------------------------------------------------------
// D-pad to mouse event generator: port checker
// Watches the top level's ports and checks event words over time.
// ----------------------------------------------------------------------------
`include "dpad_to_mouse_event_generator_macros.svh"

module dpad_checker import dpad_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic [18:0]        in_pad_buttons,
  input logic               out_valid,
  input logic               out_stall,
  input logic [1:0]         out_event_kind,
  input logic [1:0]         out_which_button,
  input logic signed [15:0] out_pointer_x,
  input logic signed [15:0] out_pointer_y,
  input logic               out_left_pressed,
  input logic [2:0]         out_held_mask,
  input logic               out_last_event,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input logic [3:0]         cfg_step_size
);

  `DPAD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable({out_event_kind, out_which_button, out_pointer_x, out_pointer_y, out_held_mask, out_last_event}), "stalled event word changed")

  `DPAD_ASSERT_SAME(a_left_mirror, clk, rst_n, out_valid, out_left_pressed == out_held_mask[0], "left_pressed differs from held mask")

  `DPAD_ASSERT_SAME(a_motion_no_btn, clk, rst_n, out_valid, (out_event_kind == EV_MOTION) == (out_which_button == BTN_NONE), "motion and button code disagree")

  `DPAD_ASSERT_SAME(a_down_held, clk, rst_n, out_valid && out_event_kind == EV_DOWN, (out_which_button == BTN_LEFT && out_held_mask[0]) || (out_which_button == BTN_MIDDLE && out_held_mask[1]) || (out_which_button == BTN_RIGHT && out_held_mask[2]), "button down for a button not held")

endmodule

bind dpad_to_mouse_event_generator dpad_checker u_dpad_checker (.*);
